// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros, included by sliding_window_mean.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Widths, reset values and control types shared by the moving average files.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 24;
	localparam int HELD_W   = 7;
	localparam int FRAC_W   = 8;

	localparam logic [HELD_W-1:0] WINDOW_SIZE_RESET = 7'd4;

	// Request from the controller to the divider.
	typedef struct packed {
		logic start;
		logic neg;
	} div_req_t;

	// Status returned by the divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- design/swm_ring.sv -----
// ----------------------------------------------------------------------------
// swm_ring
// Sample ring memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module swm_ring #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [AW-1:0]                        waddr,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]  wdata,
	input  logic                                 re,
	input  logic [AW-1:0]                        raddr,
	output logic signed [swm_pkg::SAMPLE_W-1:0]  rdata
);

	logic signed [swm_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic signed [swm_pkg::SAMPLE_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/swm_div.sv -----
// ----------------------------------------------------------------------------
// swm_div
// Restoring divider, one quotient bit per cycle, signed result toward zero.
// ----------------------------------------------------------------------------
module swm_div #(
	parameter int ND = 30
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swm_pkg::div_req_t                  req,
	input  logic [ND-1:0]                      dividend_mag,
	input  logic [swm_pkg::HELD_W-1:0]         divisor,
	output swm_pkg::div_stat_t                 stat,
	output logic signed [swm_pkg::MEAN_W-1:0]  quotient
);

	localparam int CNTW = $clog2(ND + 1);

	logic [ND-1:0]                  dvd_q;
	logic [swm_pkg::HELD_W-1:0]     rem_q;
	logic [swm_pkg::HELD_W-1:0]     dsr_q;
	logic [CNTW-1:0]                cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic                           neg_q;
	logic [swm_pkg::HELD_W:0]       rem_sh;
	logic [swm_pkg::HELD_W:0]       diff;
	logic                           ge;
	logic [ND-1:0]                  q_signed;

	// Trial subtraction for the current quotient bit.
	always_comb begin
		rem_sh = {rem_q, dvd_q[ND-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		diff   = rem_sh - {1'b0, dsr_q};
	end

	// Iteration control; the dividend register fills with quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNTW'(ND);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend_mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= ge ? diff[swm_pkg::HELD_W-1:0] : rem_sh[swm_pkg::HELD_W-1:0];
			dvd_q <= {dvd_q[ND-2:0], ge};
		end
	end

	// Apply the sign to the quotient magnitude.
	assign q_signed  = neg_q ? (~dvd_q + 1'b1) : dvd_q;
	assign quotient  = q_signed[swm_pkg::MEAN_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- design/sliding_window_mean.sv -----
// ----------------------------------------------------------------------------
// sliding_window_mean
// Boxcar moving average of signed 16-bit samples over a programmable window.
// ----------------------------------------------------------------------------
// Each accepted sample word gives one result word: the mean of the samples now
// in the window, as signed fixed point with 8 fraction bits truncated toward
// zero, together with the number of samples held. On acceptance the oldest
// sample is read from the ring memory; in the update state the running sum is
// updated, the new sample is written and the division starts. The divider then
// forms the quotient bit by bit (16 + log2(MAX_WINDOW) + 8 bits), and the
// quotient goes to the output register once the divider is done. The next word
// can be taken in the same cycle as the result appears; no word is taken while
// one is in progress. A finished result waits in the output register while the
// next word is taken; if it is still waiting when the next division ends, the
// block holds until it is taken. Writing window_size restarts an empty window
// (not in the update state, where the sum update wins); a size of zero acts as
// one, and sizes above MAX_WINDOW act as MAX_WINDOW.
`include "assert_macros.svh"

module sliding_window_mean #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [swm_pkg::HELD_W-1:0]           cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [swm_pkg::MEAN_W-1:0]    mean_value,
	output logic [swm_pkg::HELD_W-1:0]           samples_held
);

	localparam int HOLD_MAX = (1 << swm_pkg::HELD_W) - 1;
	localparam int EFF_MAX  = (MAX_WINDOW < HOLD_MAX) ? MAX_WINDOW : HOLD_MAX;
	localparam int AW       = $clog2(MAX_WINDOW);
	localparam int TOT_W    = swm_pkg::SAMPLE_W + $clog2(EFF_MAX);
	localparam int ND       = TOT_W + swm_pkg::FRAC_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV
	} state_t;

	state_t                               state_q;
	logic [swm_pkg::HELD_W-1:0]           window_size_q;
	logic [AW-1:0]                        pos_q;
	logic [AW-1:0]                        pos_s1;
	logic [swm_pkg::HELD_W-1:0]           fill_q;
	logic signed [TOT_W-1:0]              total_q;
	logic signed [swm_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                                 out_valid_q;
	logic signed [swm_pkg::MEAN_W-1:0]    mean_q;
	logic [swm_pkg::HELD_W-1:0]           held_q;

	logic [swm_pkg::HELD_W-1:0]           eff_w;
	logic [AW-1:0]                        pos_start;
	logic [AW:0]                          pos_inc;
	logic [AW-1:0]                        pos_next;
	logic                                 accept;
	logic                                 full;
	logic signed [swm_pkg::SAMPLE_W-1:0]  old_sample;
	logic signed [TOT_W-1:0]              total_new;
	logic [swm_pkg::HELD_W-1:0]           fill_new;
	logic signed [ND-1:0]                 scaled;
	logic [ND-1:0]                        scaled_mag;
	logic                                 out_free;
	swm_pkg::div_req_t                    div_req;
	swm_pkg::div_stat_t                   div_stat;
	logic signed [swm_pkg::MEAN_W-1:0]    div_quot;

	// Effective window size after clamping.
	always_comb begin
		if (window_size_q == '0) begin
			eff_w = swm_pkg::HELD_W'(1);
		end else if (int'(window_size_q) > EFF_MAX) begin
			eff_w = swm_pkg::HELD_W'(EFF_MAX);
		end else begin
			eff_w = window_size_q;
		end
	end

	// Ring addressing: wrap the stored position, then step past the new slot.
	always_comb begin
		pos_start = (int'(pos_q) >= int'(eff_w)) ? '0 : pos_q;
		pos_inc   = {1'b0, pos_s1} + 1'b1;
		pos_next  = (int'(pos_inc) >= int'(eff_w)) ? '0 : pos_inc[AW-1:0];
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Running sum update; the oldest sample drops out once the window is full.
	always_comb begin
		full      = fill_q >= eff_w;
		total_new = total_q + TOT_W'(sample_s1)
			- (full ? TOT_W'(old_sample) : TOT_W'(0));
		fill_new  = full ? eff_w : fill_q + 1'b1;
		scaled    = {total_new, {swm_pkg::FRAC_W{1'b0}}};
		scaled_mag = scaled[ND-1] ? (~scaled + 1'b1) : scaled;
	end

	assign div_req.start = (state_q == ST_UPD);
	assign div_req.neg   = total_new[TOT_W-1];

	swm_ring #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (pos_s1),
		.wdata (sample_s1),
		.re    (accept),
		.raddr (pos_start),
		.rdata (old_sample)
	);

	swm_div #(
		.ND (ND)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (div_req),
		.dividend_mag (scaled_mag),
		.divisor      (fill_new),
		.stat         (div_stat),
		.quotient     (div_quot)
	);

	// Controller: window state, sequencing and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= swm_pkg::WINDOW_SIZE_RESET;
			pos_q         <= '0;
			fill_q        <= '0;
			total_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				window_size_q <= cfg_wr_data;
				pos_q         <= '0;
				fill_q        <= '0;
				total_q       <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					total_q <= total_new;
					fill_q  <= fill_new;
					pos_q   <= pos_next;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done && out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			pos_s1    <= pos_start;
		end
		if (state_q == ST_DIV && div_stat.done && out_free) begin
			mean_q <= div_quot;
			held_q <= fill_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mean_value   = mean_q;
	assign samples_held = held_q;

	// The block takes no word while a division is under way.
	`ASSERT_IMPLIES(a_idle_div, clk, arst_n, in_ready, !div_stat.busy)
	// Checks that a result reports at least one held sample.
	`ASSERT_IMPLIES(a_held_nonzero, clk, arst_n, out_valid, samples_held != '0)
	// Checks that the fill count never exceeds the effective window.
	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= eff_w)
	// Starting a division always leaves the divider busy in the next cycle.
	`ASSERT_NEXT(a_div_start, clk, arst_n, state_q == ST_UPD, div_stat.busy)

endmodule
